@@ rtl/iutt_pkg.sv @@
// Shared types and constants for the interval update timer table.
// No dependencies; the front end, queue, engine, top, checker and testbench import it.
package iutt_pkg;

  localparam int KEY_W       = 16;
  localparam int TIME_W      = 32;
  localparam int MAX_REPORTS = 16;
  localparam int REP_W       = $clog2(MAX_REPORTS + 1);
  localparam int QDEPTH      = 2;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [1:0] OP_REG   = 2'd0;
  localparam logic [1:0] OP_UNREG = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_ADDED      = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_FIRED      = 3'd5,
    ST_NONE_FIRED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_REG,
    CMD_UNREG,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  arg;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  elapsed;
  } entry_t;

endpackage

@@ rtl/iutt_if.sv @@
// Request and response channel interfaces of the timer table.
// Plain valid/ready channels; widths follow the request and response words.
interface iutt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] client_key;
  logic [31:0] period;
  logic [31:0] delta;

  modport source (output valid, output op, output client_key, output period,
                  output delta, input ready);
  modport sink   (input valid, input op, input client_key, input period,
                  input delta, output ready);
endinterface

interface iutt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] fired_key;
  logic [31:0] elapsed;
  logic        last;

  modport source (output valid, output status, output fired_key, output elapsed,
                  output last, input ready);
  modport sink   (input valid, input status, input fired_key, input elapsed,
                  input last, output ready);
endinterface

@@ rtl/iutt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iutt_ram #(
  parameter  int WIDTH = 80,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/iutt_front.sv @@
// Front end: accepts request words, drops unused op codes, builds commands.
// Depends on iutt_pkg and iutt_in_if.
module iutt_front (
  iutt_in_if.sink          req,
  output logic             push_valid,
  output iutt_pkg::cmd_t   push_data,
  input  logic             push_ready
);
  import iutt_pkg::*;

  assign req.ready = push_ready;

  always_comb begin
    push_valid     = req.valid;
    push_data.key  = req.client_key;
    push_data.arg  = (req.op == OP_TICK) ? req.delta : req.period;
    push_data.kind = CMD_REG;
    unique case (req.op)
      OP_REG:   push_data.kind = CMD_REG;
      OP_UNREG: push_data.kind = CMD_UNREG;
      OP_TICK:  push_data.kind = CMD_TICK;
      default:  push_valid     = 1'b0;
    endcase
  end

endmodule

@@ rtl/iutt_queue.sv @@
// Short command queue between the front end and the table engine.
// Depends on iutt_pkg.
module iutt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  iutt_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output iutt_pkg::cmd_t pop_data
);
  import iutt_pkg::*;

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != (QAW + 1)'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + QAW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QAW + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QAW + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/iutt_back.sv @@
// Table engine: walks the entry RAM for searches and ticks, emits response words.
// Depends on iutt_pkg, iutt_out_if and an external iutt_ram instance.
module iutt_back #(
  parameter  int ENTRIES = 16,
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  iutt_pkg::cmd_t   pop_data,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output iutt_pkg::entry_t ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  iutt_pkg::entry_t ram_rdata,
  iutt_out_if.source       rsp
);
  import iutt_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EX, S_MV_RD, S_MV_EX, S_END} state_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  elapsed;
    logic               last;
  } res_t;

  function automatic res_t mk_res(status_t s, logic [KEY_W-1:0] k,
                                  logic [TIME_W-1:0] e, logic l);
    res_t r;
    r.status  = s;
    r.key     = k;
    r.elapsed = e;
    r.last    = l;
    return r;
  endfunction

  state_t            state;
  cmd_t              cur;
  logic [CW-1:0]     idx;
  logic [AW-1:0]     target;
  logic [CW-1:0]     count;
  logic [REP_W-1:0]  n;
  logic              pend_valid;
  logic [KEY_W-1:0]  pend_key;
  logic [TIME_W-1:0] pend_elapsed;
  logic              out_valid;
  res_t              out_res;

  logic              out_free;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat;
  logic              hit;
  logic              fire;
  logic              tick_stall;
  logic              has_room;

  assign out_free   = !out_valid || rsp.ready;
  assign sum        = {1'b0, ram_rdata.elapsed} + {1'b0, cur.arg};
  assign sat        = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign hit        = (ram_rdata.key == cur.key);
  assign fire       = (sat >= ram_rdata.period) && (n < REP_W'(MAX_REPORTS));
  assign tick_stall = fire && pend_valid && !out_free;
  assign has_room   = (count < CW'(ENTRIES));
  assign pop_ready  = (state == S_IDLE);
  assign ram_raddr  = idx[AW-1:0];

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_res.status;
  assign rsp.fired_key = out_res.key;
  assign rsp.elapsed   = out_res.elapsed;
  assign rsp.last      = out_res.last;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    case (state)
      S_EX: begin
        if (cur.kind == CMD_TICK) begin
          if (!tick_stall) begin
            ram_we            = 1'b1;
            ram_wdata.elapsed = fire ? '0 : sat;
          end
        end else if (cur.kind == CMD_REG && hit && out_free) begin
          ram_we           = 1'b1;
          ram_wdata.period = cur.arg;
        end
      end
      S_MV_EX: begin
        ram_we    = out_free;
        ram_waddr = target;
      end
      S_END: begin
        if (cur.kind == CMD_REG && has_room && out_free) begin
          ram_we            = 1'b1;
          ram_waddr         = count[AW-1:0];
          ram_wdata.key     = cur.key;
          ram_wdata.period  = cur.arg;
          ram_wdata.elapsed = '0;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cur        <= pop_data;
            idx        <= '0;
            n          <= '0;
            pend_valid <= 1'b0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          state <= (idx < count) ? S_EX : S_END;
        end
        S_EX: begin
          case (cur.kind)
            CMD_TICK: begin
              if (!tick_stall) begin
                if (fire) begin
                  if (pend_valid) begin
                    out_valid <= 1'b1;
                    out_res   <= mk_res(ST_FIRED, pend_key, pend_elapsed, 1'b0);
                  end
                  pend_valid   <= 1'b1;
                  pend_key     <= ram_rdata.key;
                  pend_elapsed <= sat;
                  n            <= n + REP_W'(1);
                end
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            CMD_REG: begin
              if (!hit) begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end else if (out_free) begin
                out_valid <= 1'b1;
                out_res   <= mk_res(ST_UPDATED, cur.key, '0, 1'b1);
                state     <= S_IDLE;
              end
            end
            CMD_UNREG: begin
              if (hit) begin
                target <= idx[AW-1:0];
                idx    <= count - CW'(1);
                state  <= S_MV_RD;
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_MV_RD: begin
          state <= S_MV_EX;
        end
        S_MV_EX: begin
          if (out_free) begin
            count     <= count - CW'(1);
            out_valid <= 1'b1;
            out_res   <= mk_res(ST_REMOVED, cur.key, '0, 1'b1);
            state     <= S_IDLE;
          end
        end
        S_END: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
            case (cur.kind)
              CMD_REG: begin
                if (has_room) begin
                  count   <= count + CW'(1);
                  out_res <= mk_res(ST_ADDED, cur.key, '0, 1'b1);
                end else begin
                  out_res <= mk_res(ST_FULL, cur.key, '0, 1'b1);
                end
              end
              CMD_UNREG: out_res <= mk_res(ST_NOT_FOUND, cur.key, '0, 1'b1);
              CMD_TICK: begin
                if (pend_valid) begin
                  out_res <= mk_res(ST_FIRED, pend_key, pend_elapsed, 1'b1);
                end else begin
                  out_res <= mk_res(ST_NONE_FIRED, cur.key, '0, 1'b1);
                end
              end
              default: out_valid <= 1'b0;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pend_only_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (cur.kind == CMD_TICK))
    else $error("pending report outside a tick");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending report left behind");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_END) |-> (count < CW'(ENTRIES)))
    else $error("append into a full table");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
    else $error("entry count jumped");

  a_reports_cap: assert property (@(posedge clk) disable iff (rst)
    n <= REP_W'(MAX_REPORTS))
    else $error("report count beyond cap");

endmodule

@@ rtl/interval_update_timer_table_top.sv @@
// Top level of the interval update timer table.
// Depends on iutt_pkg, iutt_if, iutt_ram, iutt_front, iutt_queue and iutt_back.
//
// Usage:
//   req carries one request word per handshake: op (register, unregister,
//   tick), client_key, period and delta. Op code 3 is accepted and dropped.
//   rsp carries result words: status, fired_key, elapsed and last. Register
//   and unregister give one word; a tick gives one word per fired entry (at
//   most 16) in table order, or a single none-fired word; last marks the
//   final word of each request.
//   The front end feeds a two-deep command queue, so requests are taken while
//   the engine is busy or the receiver stalls, until the queue is full. The
//   engine handles one request at a time and walks the entry RAM through its
//   single read port, one entry after another with a read state and an
//   execute state for each: a search stops at a hit or at the end, a tick
//   visits every entry, and a removal moves the last entry into its slot.
//   A stalled receiver holds the engine once the output register and one
//   pending tick report are full. Reset empties the table (count to zero)
//   and the queue; the RAM needs no clearing pass.
module interval_update_timer_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  iutt_in_if.sink    req,
  iutt_out_if.source rsp
);
  import iutt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          push_valid;
  logic          push_ready;
  cmd_t          push_data;
  logic          pop_valid;
  logic          pop_ready;
  cmd_t          pop_data;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  iutt_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  iutt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  iutt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  iutt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rsp       (rsp)
  );

endmodule

@@ verif/iutt_checker.sv @@
// Checker for the interval update timer table: watches the request and result
// channels, predicts every result word and compares it field by field.
// Depends on iutt_pkg and the channel interfaces in iutt_if.
module iutt_checker #(
  parameter int ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  iutt_in_if   req,
  iutt_out_if  rsp,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import iutt_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [15:0] key;
    logic [31:0] elapsed;
    logic        last;
  } rsp_word_t;

  logic [15:0] slot_key     [ENTRIES];
  logic [31:0] slot_period  [ENTRIES];
  logic [31:0] slot_elapsed [ENTRIES];
  int          slot_count;
  rsp_word_t   due_words [$];

  function automatic int find_slot(logic [15:0] k);
    int i;
    for (i = 0; i < slot_count; i++) begin
      if (slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void apply_request(logic [1:0] op, logic [15:0] k,
                                        logic [31:0] p, logic [31:0] d);
    int        idx;
    int        i;
    int        hits;
    int        tail;
    logic [32:0] sum33;
    logic [31:0] sum;
    rsp_word_t w;
    case (op)
      OP_REG: begin
        idx = find_slot(k);
        if (idx >= 0) begin
          slot_period[idx] = p;
          due_words.push_back('{ST_UPDATED, k, 32'd0, 1'b1});
        end else if (slot_count < ENTRIES) begin
          slot_key[slot_count]     = k;
          slot_period[slot_count]  = p;
          slot_elapsed[slot_count] = '0;
          slot_count++;
          due_words.push_back('{ST_ADDED, k, 32'd0, 1'b1});
        end else begin
          due_words.push_back('{ST_FULL, k, 32'd0, 1'b1});
        end
      end
      OP_UNREG: begin
        idx = find_slot(k);
        if (idx >= 0) begin
          tail = slot_count - 1;
          slot_key[idx]     = slot_key[tail];
          slot_period[idx]  = slot_period[tail];
          slot_elapsed[idx] = slot_elapsed[tail];
          slot_count        = tail;
          due_words.push_back('{ST_REMOVED, k, 32'd0, 1'b1});
        end else begin
          due_words.push_back('{ST_NOT_FOUND, k, 32'd0, 1'b1});
        end
      end
      OP_TICK: begin
        hits = 0;
        for (i = 0; i < slot_count; i++) begin
          sum33 = {1'b0, slot_elapsed[i]} + {1'b0, d};
          sum   = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
          slot_elapsed[i] = sum;
          if (sum >= slot_period[i] && hits < MAX_REPORTS) begin
            due_words.push_back('{ST_FIRED, slot_key[i], sum, 1'b0});
            slot_elapsed[i] = '0;
            hits++;
          end
        end
        if (hits == 0) begin
          due_words.push_back('{ST_NONE_FIRED, k, 32'd0, 1'b1});
        end else begin
          w      = due_words[due_words.size()-1];
          w.last = 1'b1;
          due_words[due_words.size()-1] = w;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    if (rst) begin
      slot_count = 0;
      fail_count = 0;
      due_words.delete();
    end else begin
      if (req.valid && req.ready) begin
        apply_request(req.op, req.client_key, req.period, req.delta);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{status_t'(rsp.status), rsp.fired_key, rsp.elapsed, rsp.last};
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word status=%0d key=%h elapsed=%h last=%b",
                   $time, got.status, got.key, got.elapsed, got.last);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (got.status !== want.status)
              $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            if (got.key !== want.key)
              $display("%0t: fired_key expected %h got %h", $time, want.key, got.key);
            if (got.elapsed !== want.elapsed)
              $display("%0t: elapsed expected %h got %h", $time, want.elapsed, got.elapsed);
            if (got.last !== want.last)
              $display("%0t: last expected %b got %b", $time, want.last, got.last);
          end
        end
      end
    end
    outstanding <= due_words.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the interval update timer table: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on iutt_pkg, iutt_if, the block's RTL and iutt_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iutt_pkg::*;

  localparam int         ENTRIES      = 16;
  localparam int         CYCLE_CAP    = 1_000_000;
  localparam int         POOL_N       = 24;
  localparam int         PHASE_WORDS  = 128;
  localparam int         TAIL_CYCLES  = 100;
  localparam logic [1:0] OP_SPARE     = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          snd_idle;
  int          rcv_idle;
  int          cycles;
  int          fail_count;
  int          outstanding;
  logic [15:0] key_pool [POOL_N];

  iutt_in_if  req ();
  iutt_out_if rsp ();

  interval_update_timer_table_top #(.ENTRIES(ENTRIES)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  iutt_checker #(.ENTRIES(ENTRIES)) u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [15:0] k,
                           input logic [31:0] p, input logic [31:0] d);
    while ($urandom_range(99) < snd_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.op         <= op;
    req.client_key <= k;
    req.period     <= p;
    req.delta      <= d;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // hold the request channel until every predicted word has been seen
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time(int short_max);
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(short_max);
    if (r < 75) return 32'd0;
    if (r < 90) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(3);
  endfunction

  task automatic send_random();
    int          r;
    logic [1:0]  op;
    logic [15:0] k;
    r = $urandom_range(99);
    if (r < 40)      op = OP_REG;
    else if (r < 62) op = OP_UNREG;
    else if (r < 95) op = OP_TICK;
    else             op = OP_SPARE;
    k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_N-1)] : 16'($urandom);
    send_word(op, k, pick_time(60), pick_time(30));
  endtask

  initial begin
    int ph;
    int n;
    req.valid      <= 1'b0;
    req.op         <= OP_REG;
    req.client_key <= '0;
    req.period     <= '0;
    req.delta      <= '0;
    snd_idle = 20;
    rcv_idle = 63;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (n = 2; n < POOL_N; n++) key_pool[n] = 16'($urandom);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, zero period, saturation, full, max fires
    send_word(OP_TICK,  16'hFFFF, 32'd0, 32'd0);
    send_word(OP_UNREG, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_REG,   16'h0000, 32'd0, 32'd0);
    send_word(OP_REG,   16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_REG,   16'h0000, 32'd5, 32'd0);
    send_word(OP_TICK,  16'h1234, 32'd0, 32'd0);
    send_word(OP_REG,   16'hAAAA, 32'd0, 32'd0);
    send_word(OP_REG,   16'h5555, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_TICK,  16'h0000, 32'd0, 32'h8000_0000);
    send_word(OP_TICK,  16'h0000, 32'd0, 32'h9000_0000);
    send_word(OP_SPARE, 16'($urandom), $urandom, $urandom);
    for (n = 1; n <= 12; n++) send_word(OP_REG, 16'(16'h0101 * n), 32'(n), 32'd0);
    send_word(OP_REG,   16'h7777, 32'd1, 32'd0);
    send_word(OP_TICK,  16'h0000, 32'd0, 32'hFFFF_FFFF);
    send_word(OP_UNREG, 16'h0000, 32'd0, 32'd0);
    send_word(OP_UNREG, 16'h0B0B, 32'd0, 32'd0);

    for (ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 20 : (ph == 1) ? 63 : 0;
      rcv_idle = (ph == 0) ? 63 : (ph == 1) ? 20 : 0;
      drain();
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99) == 0) drain();
        send_random();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/iutt_pkg.sv
rtl/iutt_if.sv
rtl/iutt_ram.sv
rtl/iutt_front.sv
rtl/iutt_queue.sv
rtl/iutt_back.sv
rtl/interval_update_timer_table_top.sv
verif/iutt_checker.sv
verif/tb.sv
